FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the half-duplex UART queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rhdq_pkg.sv
// Types and constants of the half-duplex UART queue block.
package rhdq_pkg;

   localparam int BYTE_W  = 8;
   localparam int OP_W    = 3;
   localparam int LEVEL_W = 7;
   localparam int CFG_W   = 16;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 40;

   // Operation codes carried in the low bits of the request data.
   typedef enum logic [OP_W-1:0] {
      OP_QUEUE_TX = 3'd0,
      OP_START_TX = 3'd1,
      OP_TX_DONE  = 3'd2,
      OP_RX_BYTE  = 3'd3,
      OP_POP_RX   = 3'd4,
      OP_TX_TICK  = 3'd5,
      OP_RX_CHECK = 3'd6
   } op_type;

   // Configuration register indexes.
   localparam logic CSR_TX_END_DELAY  = 1'b0;
   localparam logic CSR_RX_HOLD_TICKS = 1'b1;

   // Command from the controller to one ring.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic              clear;
      logic [BYTE_W-1:0] wdata;
   } ring_cmd_type;

endpackage

FILE: rtl/core/rhdq_ring.sv
// Byte ring buffer: synchronous memory plus head, tail and fill count.
module rhdq_ring
   import rhdq_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_cmd_type      cmd_i,
   output logic [BYTE_W-1:0] rd_data_o,
   output logic [CNT_W-1:0]  count_o
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer and count updates; a clear returns the ring to empty.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd_i.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd_i.push) begin
         head_in  = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (cmd_i.pop) begin
         tail_in  = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Memory: one write port at the head, one registered read port at the tail.
   always_ff @(posedge clock) begin
      if (cmd_i.push) begin
         mem[head_ff] <= cmd_i.wdata;
      end
      if (cmd_i.pop) begin
         rd_data_ff <= mem[tail_ff];
      end
   end

   assign rd_data_o = rd_data_ff;
   assign count_o   = count_ff;

endmodule

FILE: rtl/core/rs485_half_duplex_uart_queues.sv
// Top level of the half-duplex RS-485 UART buffer controller with two rings.
// A request is registered as pending together with its ring read, then its result
// is captured in the result register; a new request waits while one is pending.
// Reset is synchronous and clears pointers, counts, counters, control flags and config.
// Ring memory contents are not cleared; there is no clearing pass after reset.
`include "assert_macros.svh"

module rs485_half_duplex_uart_queues
   import rhdq_pkg::*;
#(
   parameter int TX_DEPTH = 64,
   parameter int RX_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   // Request channel.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // operation[2:0], data_byte[10:3]
   // Result channel.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // send_strobe[0], send_byte[8:1],
                                        // read_valid[9], read_byte[17:10],
                                        // driver_enable[18], sending[19],
                                        // receive_active[20], tx_level[27:21],
                                        // rx_level[34:28], dropped[35]
   // Configuration write port.
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

   ring_cmd_type         tx_cmd, rx_cmd;
   logic [BYTE_W-1:0]    tx_rd_data, rx_rd_data;
   logic [TX_CNT_W-1:0]  tx_count;
   logic [RX_CNT_W-1:0]  rx_count;
   logic                 tx_full, rx_full;

   logic [CFG_W-1:0]     tx_end_delay_ff, rx_hold_ticks_ff;
   logic                 send_ff, send_in;
   logic                 enable_ff, enable_in;
   logic [CFG_W-1:0]     end_cnt_ff, end_cnt_in;
   logic [CFG_W-1:0]     hold_cnt_ff, hold_cnt_in;
   logic                 pend_ff;
   logic                 strobe_ff, strobe_in;
   logic                 read_ff, read_in;
   logic                 drop_ff, drop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 accept;
   op_type               op;
   logic [BYTE_W-1:0]    data_byte;
   logic [TX_CNT_W+LEVEL_W-1:0] tx_level_wide;
   logic [RX_CNT_W+LEVEL_W-1:0] rx_level_wide;

   // Transmit and receive rings.
   rhdq_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd_i     (tx_cmd),
      .rd_data_o (tx_rd_data),
      .count_o   (tx_count)
   );

   rhdq_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd_i     (rx_cmd),
      .rd_data_o (rx_rd_data),
      .count_o   (rx_count)
   );

   assign tx_full = (tx_count == TX_CNT_W'(TX_DEPTH));
   assign rx_full = (rx_count == RX_CNT_W'(RX_DEPTH));

   // Nothing is taken during reset; one request in flight, and the result
   // register must be free or draining.
   assign req_tready = !reset && !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tdata[OP_W-1:0]);
   assign data_byte  = req_tdata[OP_W +: BYTE_W];

   // Operation decode: ring commands and control state updates.
   always_comb begin
      tx_cmd       = '0;
      rx_cmd       = '0;
      tx_cmd.wdata = data_byte;
      rx_cmd.wdata = data_byte;
      send_in      = send_ff;
      enable_in    = enable_ff;
      end_cnt_in   = end_cnt_ff;
      hold_cnt_in  = hold_cnt_ff;
      strobe_in    = 1'b0;
      read_in      = 1'b0;
      drop_in      = 1'b0;
      if (accept) begin
         case (op)
            OP_QUEUE_TX: begin
               if (tx_full) begin
                  drop_in = 1'b1;
               end else begin
                  tx_cmd.push = 1'b1;
               end
            end
            OP_START_TX, OP_TX_DONE: begin
               if (op == OP_START_TX) begin
                  send_in    = 1'b1;
                  enable_in  = 1'b1;
                  end_cnt_in = tx_end_delay_ff;
               end
               if (tx_count != '0) begin
                  tx_cmd.pop = 1'b1;
                  strobe_in  = 1'b1;
                  end_cnt_in = tx_end_delay_ff;
               end else if (tx_end_delay_ff == '0) begin
                  send_in      = 1'b0;
                  enable_in    = 1'b0;
                  tx_cmd.clear = 1'b1;
               end
            end
            OP_RX_BYTE: begin
               if (send_ff || rx_full) begin
                  drop_in = 1'b1;
               end else begin
                  rx_cmd.push = 1'b1;
                  hold_cnt_in = rx_hold_ticks_ff;
               end
            end
            OP_POP_RX: begin
               if (rx_count != '0) begin
                  rx_cmd.pop = 1'b1;
                  read_in    = 1'b1;
               end
            end
            OP_TX_TICK: begin
               if (end_cnt_ff == '0) begin
                  send_in      = 1'b0;
                  enable_in    = 1'b0;
                  tx_cmd.clear = 1'b1;
               end else begin
                  end_cnt_in = end_cnt_ff - 1'b1;
               end
            end
            OP_RX_CHECK: begin
               if (hold_cnt_ff != '0) begin
                  hold_cnt_in = hold_cnt_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         send_ff          <= 1'b0;
         enable_ff        <= 1'b0;
         end_cnt_ff       <= '0;
         hold_cnt_ff      <= '0;
         pend_ff          <= 1'b0;
         tx_end_delay_ff  <= '0;
         rx_hold_ticks_ff <= '0;
      end else begin
         send_ff     <= send_in;
         enable_ff   <= enable_in;
         end_cnt_ff  <= end_cnt_in;
         hold_cnt_ff <= hold_cnt_in;
         pend_ff     <= accept;
         if (csr_we) begin
            case (csr_index)
               CSR_TX_END_DELAY:  tx_end_delay_ff  <= csr_wdata;
               CSR_RX_HOLD_TICKS: rx_hold_ticks_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Per-request flags, registered on accept alongside the ring read data.
   always_ff @(posedge clock) begin
      if (accept) begin
         strobe_ff <= strobe_in;
         read_ff   <= read_in;
         drop_ff   <= drop_in;
      end
   end

   // Result assembly from the read data and the state after the step.
   assign tx_level_wide = {{LEVEL_W{1'b0}}, tx_count};
   assign rx_level_wide = {{LEVEL_W{1'b0}}, rx_count};

   always_comb begin
      rsp_data_in = {
         {(RSP_W - 36){1'b0}},
         drop_ff,
         rx_level_wide[LEVEL_W-1:0],
         tx_level_wide[LEVEL_W-1:0],
         (hold_cnt_ff != '0),
         send_ff,
         enable_ff,
         read_ff ? rx_rd_data : {BYTE_W{1'b0}},
         read_ff,
         strobe_ff ? tx_rd_data : {BYTE_W{1'b0}},
         strobe_ff
      };
      rsp_valid_in = pend_ff ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Result output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Driver enable and the sending flag are raised and released together.
   `ASSERT_ALWAYS(a_enable_tracks_send, clock, reset, enable_ff == send_ff, "driver enable and sending flag differ")
   // A request in flight always produces a result in the next cycle.
   `ASSERT_NEXT(a_pend_to_result, clock, reset, pend_ff, rsp_valid_ff, "pending request produced no result")
   // Fill counts never exceed the ring depths.
   `ASSERT_ALWAYS(a_tx_count_bound, clock, reset, tx_count <= TX_CNT_W'(TX_DEPTH), "transmit ring overfilled")
   `ASSERT_ALWAYS(a_rx_count_bound, clock, reset, rx_count <= RX_CNT_W'(RX_DEPTH), "receive ring overfilled")

endmodule

FILE: tb/rs485_half_duplex_uart_queues_tb.sv
// Self-checking testbench for the half-duplex RS-485 UART queue block.
module rs485_half_duplex_uart_queues_tb;
   import rhdq_pkg::*;

   localparam int RING_DEPTH   = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int FIELD_COUNT  = 10;

   // Operation code seven has no meaning in the block and only reports status.
   localparam logic [OP_W-1:0] OP_IDLE = 3'd7;

   // Status word as it comes back on rsp_tdata, send_strobe in bit zero.
   typedef struct packed {
      logic               dropped;
      logic [LEVEL_W-1:0] rx_level;
      logic [LEVEL_W-1:0] tx_level;
      logic               receive_active;
      logic               sending;
      logic               driver_enable;
      logic [BYTE_W-1:0]  read_byte;
      logic               read_valid;
      logic [BYTE_W-1:0]  send_byte;
      logic               send_strobe;
   } ring_status_type;

   // Mirror of both rings and the driver control, plus the queue of predicted status words.
   class ring_scoreboard;
      logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
      logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
      int unsigned       tx_head, tx_tail, tx_count;
      int unsigned       rx_head, rx_tail, rx_count;
      bit                send_flag, enable_level;
      bit [CFG_W-1:0]    end_count, hold_count;
      bit [CFG_W-1:0]    tx_end_delay, rx_hold_ticks;
      logic [RSP_W-1:0]  expected_status [$];
      int unsigned       failures, results_seen;
      string             field_name [FIELD_COUNT] = '{"send_strobe", "send_byte",
         "read_valid", "read_byte", "driver_enable", "sending", "receive_active",
         "tx_level", "rx_level", "dropped"};
      int unsigned       field_lo [FIELD_COUNT] = '{0, 1, 9, 10, 18, 19, 20, 21, 28, 35};
      int unsigned       field_width [FIELD_COUNT] = '{1, 8, 1, 8, 1, 1, 1, 7, 7, 1};

      function void set_register(logic index, bit [CFG_W-1:0] value);
         if (index == CSR_TX_END_DELAY) begin
            tx_end_delay = value;
         end else begin
            rx_hold_ticks = value;
         end
      endfunction

      // Dropping the driver also throws away whatever is left in the transmit ring.
      function void release_driver();
         send_flag = 1'b0;
         enable_level = 1'b0;
         if (tx_count != 0 || tx_head != tx_tail) begin
            tx_head = 0;
            tx_tail = 0;
            tx_count = 0;
         end
      endfunction

      // Hand the next queued byte to the serial transmitter, or release at once without delay.
      function void hand_next_byte(ref ring_status_type status);
         if (tx_count != 0) begin
            tx_count--;
            status.send_strobe = 1'b1;
            status.send_byte = tx_ring[tx_tail];
            tx_tail = (tx_tail + 1) % RING_DEPTH;
            end_count = tx_end_delay;
         end else if (tx_end_delay == 0) begin
            release_driver();
         end
      endfunction

      // Work out the status word that one accepted request produces.
      function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
         ring_status_type status;
         status = '0;
         case (op)
            OP_QUEUE_TX: begin
               if (tx_count < RING_DEPTH) begin
                  tx_ring[tx_head] = data;
                  tx_head = (tx_head + 1) % RING_DEPTH;
                  tx_count++;
               end else begin
                  status.dropped = 1'b1;
               end
            end
            OP_START_TX: begin
               send_flag = 1'b1;
               end_count = tx_end_delay;
               enable_level = 1'b1;
               hand_next_byte(status);
            end
            OP_TX_DONE: begin
               hand_next_byte(status);
            end
            OP_RX_BYTE: begin
               if (send_flag || rx_count >= RING_DEPTH) begin
                  status.dropped = 1'b1;
               end else begin
                  rx_ring[rx_head] = data;
                  rx_head = (rx_head + 1) % RING_DEPTH;
                  rx_count++;
                  hold_count = rx_hold_ticks;
               end
            end
            OP_POP_RX: begin
               if (rx_count != 0) begin
                  rx_count--;
                  status.read_valid = 1'b1;
                  status.read_byte = rx_ring[rx_tail];
                  rx_tail = (rx_tail + 1) % RING_DEPTH;
               end
            end
            OP_TX_TICK: begin
               if (end_count == 0) begin
                  release_driver();
               end else begin
                  end_count--;
               end
            end
            OP_RX_CHECK: begin
               if (hold_count != 0) begin
                  hold_count--;
               end
            end
            default: begin
            end
         endcase
         status.driver_enable = enable_level;
         status.sending = send_flag;
         status.receive_active = (hold_count != 0);
         status.tx_level = LEVEL_W'(tx_count);
         status.rx_level = LEVEL_W'(rx_count);
         expected_status.push_back(RSP_W'(status));
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%s", what);
         end
      endfunction

      // Compare one result transfer with the oldest prediction, field by field.
      function void check_result(logic [RSP_W-1:0] actual);
         logic [RSP_W-1:0] predicted;
         logic [RSP_W-1:0] mask;
         results_seen++;
         if (expected_status.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing predicted: %h",
                                   results_seen, actual));
            return;
         end
         predicted = expected_status.pop_front();
         foreach (field_name[i]) begin
            mask = {RSP_W{1'b1}} >> (RSP_W - field_width[i]);
            if (((actual >> field_lo[i]) & mask) !== ((predicted >> field_lo[i]) & mask)) begin
               note_failure($sformatf("result %0d, %s: expected %0h, got %0h", results_seen,
                                      field_name[i], (predicted >> field_lo[i]) & mask,
                                      (actual >> field_lo[i]) & mask));
            end
         end
      endfunction

      function int outstanding();
         return expected_status.size();
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tready = 1'b0;
   logic             csr_we     = 1'b0;
   logic             csr_index  = 1'b0;
   logic [CFG_W-1:0] csr_wdata  = '0;
   logic             req_tready;
   logic             rsp_tvalid;
   logic [RSP_W-1:0] rsp_tdata;

   ring_scoreboard   sb;
   bit               steady;
   bit [CFG_W-1:0]   cfg_delay, cfg_hold;
   int               items_sent;
   int               ready_stall;
   int               quiet_cycles;

   rs485_half_duplex_uart_queues #(
      .TX_DEPTH(RING_DEPTH),
      .RX_DEPTH(RING_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Gap length for either side: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end else if (roll < 94) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 30);
      end
   endfunction

   // Mostly short bursts, now and then a long one that can overrun a ring.
   function automatic int burst_length();
      if ($urandom_range(0, 99) < 6) begin
         return $urandom_range(60, 70);
      end else begin
         return $urandom_range(1, 8);
      end
   endfunction

   // Any byte value.
   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Result side: check every transfer and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         if (ready_stall != 0) begin
            ready_stall = ready_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            ready_stall = pick_gap();
         end
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("rs485_half_duplex_uart_queues_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request, wait for its transfer, then idle for a random gap.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
      int gap;
      req_tdata <= REQ_W'({data, op});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, data);
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every predicted result has come back and the block is quiet.
   task automatic settle_results();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] hold);
      csr_we <= 1'b1;
      csr_index <= CSR_TX_END_DELAY;
      csr_wdata <= delay;
      @(posedge clock);
      sb.set_register(CSR_TX_END_DELAY, delay);
      csr_index <= CSR_RX_HOLD_TICKS;
      csr_wdata <= hold;
      @(posedge clock);
      sb.set_register(CSR_RX_HOLD_TICKS, hold);
      csr_we <= 1'b0;
      cfg_delay = delay;
      cfg_hold = hold;
   endtask

   // One setting of the registers, then random transmit, receive and mixed sequences.
   task automatic run_phase(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] hold,
                            input int count, input bit fill_rings);
      int stop_at;
      int n;
      bit tx_filled;
      bit rx_filled;
      settle_results();
      configure(delay, hold);
      steady = 1'b0;
      tx_filled = !fill_rings;
      rx_filled = !fill_rings;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            steady = !steady;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               // Queue a message, send it out byte by byte and let the end delay run down.
               n = tx_filled ? burst_length() : $urandom_range(65, 70);
               tx_filled = 1'b1;
               repeat (n) begin
                  if ($urandom_range(0, 9) == 0) begin
                     send_item(OP_RX_BYTE, rand_byte());
                  end
                  send_item(OP_QUEUE_TX, rand_byte());
               end
               send_item(OP_START_TX, rand_byte());
               if ($urandom_range(0, 4) == 0) begin
                  n = n / 2;
               end else begin
                  n = n - 1 + $urandom_range(0, 2);
               end
               repeat (n) send_item(OP_TX_DONE, rand_byte());
               repeat (((cfg_delay > 5) ? 5 : int'(cfg_delay)) + 1 + $urandom_range(0, 1))
                  send_item(OP_TX_TICK, rand_byte());
            end
            7, 8, 9, 10, 11, 12: begin
               // Take bytes from the line, watch the hold counter, then drain the ring.
               n = rx_filled ? burst_length() : $urandom_range(65, 70);
               rx_filled = 1'b1;
               repeat (n) begin
                  send_item(OP_RX_BYTE, rand_byte());
                  if ($urandom_range(0, 3) == 0) begin
                     send_item(OP_RX_CHECK, rand_byte());
                  end
               end
               repeat (((cfg_hold > 4) ? 4 : int'(cfg_hold)) + $urandom_range(0, 1))
                  send_item(OP_RX_CHECK, rand_byte());
               if ($urandom_range(0, 3) == 0) begin
                  n = n / 2;
               end else begin
                  n = n + $urandom_range(0, 2);
               end
               repeat (n) send_item(OP_POP_RX, rand_byte());
            end
            13, 14, 15, 16: begin
               repeat ($urandom_range(1, 6))
                  send_item(OP_W'($urandom_range(OP_TX_DONE, OP_RX_CHECK)), rand_byte());
            end
            default: begin
               repeat ($urandom_range(1, 6))
                  send_item(OP_W'($urandom_range(OP_QUEUE_TX, OP_IDLE)), rand_byte());
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      configure(16'd2, 16'd3);

      // Directed: empty pop, send with restart, release by tick and with leftovers.
      send_item(OP_POP_RX, 8'h00);
      send_item(OP_QUEUE_TX, 8'h00);
      send_item(OP_QUEUE_TX, 8'hFF);
      send_item(OP_QUEUE_TX, 8'hA5);
      send_item(OP_QUEUE_TX, 8'h5A);
      send_item(OP_IDLE, 8'hFF);
      send_item(OP_START_TX, 8'h00);
      // A byte from the line while sending is discarded.
      send_item(OP_RX_BYTE, 8'h33);
      // A second start while sending begins afresh.
      send_item(OP_START_TX, 8'h00);
      send_item(OP_TX_DONE, 8'h00);
      send_item(OP_TX_DONE, 8'h00);
      // Transmit done on an empty ring with a nonzero end delay changes nothing.
      send_item(OP_TX_DONE, 8'h00);
      repeat (3) send_item(OP_TX_TICK, 8'h00);
      // Tick while not sending follows the same release rule.
      send_item(OP_TX_TICK, 8'h00);
      send_item(OP_RX_BYTE, 8'h00);
      send_item(OP_RX_BYTE, 8'hFF);
      send_item(OP_RX_CHECK, 8'h00);
      send_item(OP_POP_RX, 8'h00);
      send_item(OP_POP_RX, 8'h00);
      // Release with a byte still queued clears the transmit ring.
      send_item(OP_QUEUE_TX, 8'hC3);
      send_item(OP_QUEUE_TX, 8'h3C);
      send_item(OP_START_TX, 8'h00);
      repeat (3) send_item(OP_TX_TICK, 8'h00);

      run_phase(16'd0, 16'd0, 240, 1'b1);
      run_phase(16'd1, 16'd1, 240, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 240, 1'b1);
      run_phase(16'd5, 16'd2, 240, 1'b0);
      run_phase(16'd0, 16'hFFFF, 240, 1'b1);
      run_phase(16'hFFFF, 16'd0, 240, 1'b0);
      settle_results();

      if (sb.failures == 0) begin
         $display("rs485_half_duplex_uart_queues_tb OK");
      end else begin
         $display("rs485_half_duplex_uart_queues_tb NOT OK");
      end
      $finish;
   end

endmodule
